FILE: rtl/bmcs_pkg.sv
// shared constants for the byte memory cpu step core
// field widths, command codes, opcodes and status codes; no dependencies
package bmcs_pkg;

    localparam int MEM_BYTES_DEF = 1024;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 10;
    localparam int DATA_W = 8;
    localparam int ST_W   = 3;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SETPC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd3;

    localparam logic [DATA_W-1:0] OP_ADD    = 8'h0A;
    localparam logic [DATA_W-1:0] OP_SUB    = 8'h13;
    localparam logic [DATA_W-1:0] OP_JUMP   = 8'h16;
    localparam logic [DATA_W-1:0] OP_BRANCH = 8'h17;
    localparam logic [DATA_W-1:0] OP_HALT   = 8'hFF;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_HALTED   = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_OP   = 3'd2;
    localparam logic [ST_W-1:0] ST_PAST_TOP = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_ADDR = 3'd4;

endpackage

FILE: rtl/bmcs_if.sv
// request and response channels of the byte memory cpu step core
// valid/ready handshake with payload; depends on bmcs_pkg
interface bmcs_req_if
    import bmcs_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;

    modport source (output valid, output cmd, output addr, output data, input ready);
    modport sink (input valid, input cmd, input addr, input data, output ready);
endinterface

interface bmcs_rsp_if
    import bmcs_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] pc;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output pc, output status, output read_data, input ready);
    modport sink (input valid, input pc, input status, input read_data, output ready);
endinterface

FILE: rtl/byte_memory_cpu_step_core.sv
// byte memory cpu step core: one request writes, reads, sets pc or runs one instruction
// write and set pc go straight to the response state, read passes through a read state;
// execute fetches the opcode and its operands (add and sub: opcode, three operand bytes, read, write back)
// one request in flight; the next is taken the cycle after the response is loaded,
// so requests never overlap, paced by the single memory port
// after reset the memory is cleared, one byte a cycle, up to the last address; no request before
module byte_memory_cpu_step_core
    import bmcs_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bmcs_req_if.sink   req,
    bmcs_rsp_if.source rsp
);

    localparam int          AW   = $clog2(MEM_BYTES);
    localparam logic [16:0] LIM  = 17'(MEM_BYTES);
    localparam logic [AW-1:0] LAST = AW'(MEM_BYTES - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_OP    = 4'd3;
    localparam logic [3:0] S_B1    = 4'd4;
    localparam logic [3:0] S_B2    = 4'd5;
    localparam logic [3:0] S_B3    = 4'd6;
    localparam logic [3:0] S_OPND  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [DATA_W-1:0] mem [MEM_BYTES];
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]     pc_reg, pc_next;
    logic [DATA_W-1:0] op_reg, op_next;
    logic [DATA_W-1:0] b1_reg, b1_next;
    logic [DATA_W-1:0] b2_reg, b2_next;
    logic [AW-1:0]     a_reg, a_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [DATA_W-1:0] rdat_reg, rdat_next;
    logic              out_vld_reg, out_vld_next;
    logic [ADDR_W-1:0] out_pc_reg, out_pc_next;
    logic [ST_W-1:0]   out_st_reg, out_st_next;
    logic [DATA_W-1:0] out_rdat_reg, out_rdat_next;

    logic [16:0] pc17;
    logic [17:0] br_tgt;
    logic [15:0] word;
    logic        addr_ok;

    // single port memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pc_next       = pc_reg;
        op_next       = op_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        a_next        = a_reg;
        st_next       = st_reg;
        rdat_next     = rdat_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        out_pc_next   = out_pc_reg;
        out_st_next   = out_st_reg;
        out_rdat_next = out_rdat_reg;
        mem_we        = 1'b0;
        mem_addr      = pc_reg;
        mem_wdata     = '0;
        req.ready     = (state_reg == S_IDLE);

        pc17    = 17'(pc_reg);
        addr_ok = 17'(req.addr) < LIM;
        word    = {b1_reg, mem_rdata};
        br_tgt  = {1'b0, pc17} + {{10{mem_rdata[7]}}, mem_rdata};

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                if (clr_cnt_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    st_next    = ST_OK;
                    rdat_next  = '0;
                    state_next = S_DONE;
                    case (req.cmd)
                        CMD_WRITE:
                        begin
                            if (addr_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = AW'(req.addr);
                                mem_wdata = req.data;
                            end
                            else
                            begin
                                st_next = ST_BAD_ADDR;
                            end
                        end
                        CMD_READ:
                        begin
                            if (addr_ok)
                            begin
                                mem_addr   = AW'(req.addr);
                                state_next = S_RD;
                            end
                            else
                            begin
                                st_next = ST_BAD_ADDR;
                            end
                        end
                        CMD_SETPC:
                        begin
                            if (addr_ok)
                            begin
                                pc_next = AW'(req.addr);
                            end
                            else
                            begin
                                st_next = ST_BAD_ADDR;
                            end
                        end
                        default:
                        begin
                            mem_addr   = pc_reg;
                            state_next = S_OP;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                rdat_next  = mem_rdata;
                state_next = S_DONE;
            end
            S_OP:
            begin
                op_next    = mem_rdata;
                mem_addr   = AW'(pc17 + 17'd1);
                state_next = S_DONE;
                case (mem_rdata)
                    OP_ADD, OP_SUB:
                    begin
                        if (pc17 + 17'd4 >= LIM)
                        begin
                            st_next = ST_PAST_TOP;
                        end
                        else
                        begin
                            state_next = S_B1;
                        end
                    end
                    OP_JUMP:
                    begin
                        if (pc17 + 17'd2 >= LIM)
                        begin
                            st_next = ST_PAST_TOP;
                        end
                        else
                        begin
                            state_next = S_B1;
                        end
                    end
                    OP_BRANCH:
                    begin
                        if (pc17 + 17'd1 >= LIM)
                        begin
                            st_next = ST_PAST_TOP;
                        end
                        else
                        begin
                            state_next = S_B1;
                        end
                    end
                    OP_HALT:
                    begin
                        st_next = ST_HALTED;
                    end
                    default:
                    begin
                        st_next = ST_BAD_OP;
                    end
                endcase
            end
            S_B1:
            begin
                if (op_reg == OP_BRANCH)
                begin
                    state_next = S_DONE;
                    if (br_tgt[17])
                    begin
                        st_next = ST_BAD_ADDR;
                    end
                    else if (br_tgt[16:0] >= LIM)
                    begin
                        st_next = ST_PAST_TOP;
                    end
                    else
                    begin
                        pc_next = AW'(br_tgt[16:0]);
                    end
                end
                else
                begin
                    b1_next    = mem_rdata;
                    mem_addr   = AW'(pc17 + 17'd2);
                    state_next = S_B2;
                end
            end
            S_B2:
            begin
                if (op_reg == OP_JUMP)
                begin
                    state_next = S_DONE;
                    if (17'(word) >= LIM)
                    begin
                        st_next = ST_PAST_TOP;
                    end
                    else
                    begin
                        pc_next = AW'(word);
                    end
                end
                else
                begin
                    b2_next    = mem_rdata;
                    mem_addr   = AW'(pc17 + 17'd3);
                    state_next = S_B3;
                end
            end
            S_B3:
            begin
                // operand address: high byte then low byte
                if (17'({b2_reg, mem_rdata}) >= LIM)
                begin
                    st_next    = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    a_next     = AW'({b2_reg, mem_rdata});
                    mem_addr   = AW'({b2_reg, mem_rdata});
                    state_next = S_OPND;
                end
            end
            S_OPND:
            begin
                mem_we     = 1'b1;
                mem_addr   = a_reg;
                mem_wdata  = (op_reg == OP_ADD) ? (mem_rdata + b1_reg) : (mem_rdata - b1_reg);
                pc_next    = AW'(pc17 + 17'd4);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next  = 1'b1;
                    out_pc_next   = pc17[ADDR_W-1:0];
                    out_st_next   = st_reg;
                    out_rdat_next = rdat_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            pc_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pc_reg      <= pc_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        a_reg        <= a_next;
        st_reg       <= st_next;
        rdat_reg     <= rdat_next;
        out_pc_reg   <= out_pc_next;
        out_st_reg   <= out_st_next;
        out_rdat_reg <= out_rdat_next;
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.pc        = out_pc_reg;
    assign rsp.status    = out_st_reg;
    assign rsp.read_data = out_rdat_reg;

    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        17'(pc_reg) < LIM)
        else $error("program counter beyond memory");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> out_st_reg <= ST_BAD_ADDR)
        else $error("undefined status code");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_IDLE || state_reg == S_OPND))
        else $error("memory write outside clear, request or write back");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg) == S_DONE)
        else $error("response loaded outside done state");

    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_st_reg != ST_OK |-> out_rdat_reg == '0)
        else $error("read data on failed request");

endmodule

FILE: sim/byte_memory_cpu_step_core_tb.sv
// testbench for byte_memory_cpu_step_core: directed and random requests are
// checked against an in-bench model of the byte memory and program counter
// depends on bmcs_pkg, bmcs_if and the core itself
module byte_memory_cpu_step_core_tb;
    import bmcs_pkg::*;

    localparam int MEM_SIZE     = MEM_BYTES_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } cpu_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] read_data;
    } cpu_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bmcs_req_if req_bus ();
    bmcs_rsp_if rsp_bus ();

    byte_memory_cpu_step_core #(
        .MEM_BYTES(MEM_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_bus.sink),
        .rsp(rsp_bus.source)
    );

    always #5 clk = ~clk;

    logic [DATA_W-1:0] mem_image [MEM_SIZE];
    logic [ADDR_W-1:0] pc_image;

    cpu_req_t pending_reqs [$];
    cpu_rsp_t expected_rsps [$];

    int total_items = 0;
    int issued = 0;
    int checked = 0;
    int fail_count = 0;
    int cycle_count = 0;
    logic req_taken = 1'b0;

    function automatic logic [DATA_W-1:0] mem_byte(int unsigned a);
        return (a < MEM_SIZE) ? mem_image[a] : '0;
    endfunction

    function automatic logic [ST_W-1:0] step_instruction();
        int unsigned here;
        int unsigned target;
        int rel;
        logic [DATA_W-1:0] opcode;
        logic [DATA_W-1:0] operand;
        here = pc_image;
        opcode = mem_byte(here);
        if (opcode == OP_ADD || opcode == OP_SUB) begin
            if (here + 4 >= MEM_SIZE)
                return ST_PAST_TOP;
            operand = mem_byte(here + 1);
            target = {mem_byte(here + 2), mem_byte(here + 3)};
            if (target >= MEM_SIZE)
                return ST_BAD_ADDR;
            if (opcode == OP_ADD)
                mem_image[target] = mem_image[target] + operand;
            else
                mem_image[target] = mem_image[target] - operand;
            pc_image = ADDR_W'(here + 4);
            return ST_OK;
        end
        if (opcode == OP_JUMP) begin
            if (here + 2 >= MEM_SIZE)
                return ST_PAST_TOP;
            target = {mem_byte(here + 1), mem_byte(here + 2)};
            if (target >= MEM_SIZE)
                return ST_PAST_TOP;
            pc_image = ADDR_W'(target);
            return ST_OK;
        end
        if (opcode == OP_BRANCH) begin
            if (here + 1 >= MEM_SIZE)
                return ST_PAST_TOP;
            operand = mem_byte(here + 1);
            rel = int'(here) + (operand[7] ? int'(operand) - 256 : int'(operand));
            if (rel < 0)
                return ST_BAD_ADDR;
            if (rel >= MEM_SIZE)
                return ST_PAST_TOP;
            pc_image = ADDR_W'(rel);
            return ST_OK;
        end
        if (opcode == OP_HALT)
            return ST_HALTED;
        return ST_BAD_OP;
    endfunction

    function automatic cpu_rsp_t predict_response(cpu_req_t r);
        cpu_rsp_t e;
        e.status = ST_OK;
        e.read_data = '0;
        if (r.cmd != CMD_EXEC && r.addr >= MEM_SIZE)
            e.status = ST_BAD_ADDR;
        else begin
            case (r.cmd)
                CMD_WRITE: mem_image[r.addr] = r.data;
                CMD_READ:  e.read_data = mem_image[r.addr];
                CMD_SETPC: pc_image = r.addr;
                default:   e.status = step_instruction();
            endcase
        end
        e.pc = pc_image;
        return e;
    endfunction

    function automatic void push_req(logic [CMD_W-1:0] op_cmd, int unsigned at,
                                     int unsigned value);
        cpu_req_t r;
        r.cmd = op_cmd;
        r.addr = ADDR_W'(at);
        r.data = DATA_W'(value);
        pending_reqs.push_back(r);
    endfunction

    // random instruction written at a random place, pc set there, then a few steps
    function automatic void queue_program();
        int unsigned base;
        int unsigned target;
        int unsigned len;
        int unsigned pick;
        int unsigned steps;
        logic [DATA_W-1:0] code [4];
        base = ($urandom_range(9) == 0) ? $urandom_range(MEM_SIZE - 1, MEM_SIZE - 12)
                                        : $urandom_range(MEM_SIZE - 1);
        foreach (code[i])
            code[i] = DATA_W'($urandom);
        target = MEM_SIZE;
        pick = $urandom_range(99);
        if (pick < 50) begin
            code[0] = (pick < 30) ? OP_ADD : OP_SUB;
            target = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF)
                                              : $urandom_range(MEM_SIZE - 1);
            code[2] = DATA_W'(target >> 8);
            code[3] = DATA_W'(target);
            len = 4;
        end else if (pick < 65) begin
            code[0] = OP_JUMP;
            target = ($urandom_range(99) < 85) ? $urandom_range(MEM_SIZE - 1)
                                               : $urandom_range(16'hFFFF);
            code[1] = DATA_W'(target >> 8);
            code[2] = DATA_W'(target);
            target = MEM_SIZE;
            len = 3;
        end else if (pick < 85) begin
            code[0] = OP_BRANCH;
            len = 2;
        end else if (pick < 92) begin
            code[0] = OP_HALT;
            len = 1;
        end else
            len = 4;
        for (int i = 0; i < len; i++)
            if (base + i < MEM_SIZE)
                push_req(CMD_WRITE, base + i, code[i]);
        push_req(CMD_SETPC, base, $urandom_range(255));
        steps = $urandom_range(1, 3);
        for (int i = 0; i < steps; i++)
            push_req(CMD_EXEC, $urandom_range(MEM_SIZE - 1), $urandom_range(255));
        if (target < MEM_SIZE)
            push_req(CMD_READ, target, $urandom_range(255));
    endfunction

    function automatic bit sender_idles();
        int phase;
        phase = (total_items == 0) ? 0 : issued * 4 / total_items;
        if (phase == 1)
            return $urandom_range(99) < 73;
        if (phase == 3)
            return $urandom_range(99) < 16;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        int phase;
        phase = (total_items == 0) ? 0 : checked * 4 / total_items;
        if (phase == 2)
            return $urandom_range(99) < 73;
        if (phase == 3)
            return $urandom_range(99) < 16;
        return 1'b0;
    endfunction

    // accepted requests update the model, then the request driver
    always @(posedge clk) begin
        cpu_req_t seen;
        if (rst_n && req_bus.valid && req_bus.ready) begin
            seen.cmd = req_bus.cmd;
            seen.addr = req_bus.addr;
            seen.data = req_bus.data;
            expected_rsps.push_back(predict_response(seen));
        end
        req_taken <= rst_n && req_bus.valid && req_bus.ready;
    end

    always @(negedge clk) begin
        cpu_req_t next_req;
        if (rst_n && (!req_bus.valid || req_taken)) begin
            if (pending_reqs.size() != 0 && !sender_idles()) begin
                next_req = pending_reqs.pop_front();
                issued++;
                req_bus.valid <= 1'b1;
                req_bus.cmd <= next_req.cmd;
                req_bus.addr <= next_req.addr;
                req_bus.data <= next_req.data;
            end else
                req_bus.valid <= 1'b0;
        end
    end

    // response ready with random stalls, and response monitor
    always @(negedge clk)
        rsp_bus.ready <= rst_n && !receiver_stalls();

    always @(posedge clk) begin
        cpu_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected response: pc=%0d status=%0d read_data=%02h",
                             rsp_bus.pc, rsp_bus.status, rsp_bus.read_data);
                fail_count++;
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_bus.pc !== want.pc || rsp_bus.status !== want.status ||
                    rsp_bus.read_data !== want.read_data) begin
                    if (fail_count < MAX_REPORTS)
                        $display("response %0d mismatch: expected pc=%0d status=%0d rd=%02h, got pc=%0d status=%0d rd=%02h",
                                 checked, want.pc, want.status, want.read_data,
                                 rsp_bus.pc, rsp_bus.status, rsp_bus.read_data);
                    fail_count++;
                end
            end
            checked++;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int goal;
        int unsigned pick;
        int unsigned at;
        req_bus.valid = 1'b0;
        req_bus.cmd = CMD_WRITE;
        req_bus.addr = '0;
        req_bus.data = '0;
        rsp_bus.ready = 1'b0;
        foreach (mem_image[i])
            mem_image[i] = '0;
        pc_image = '0;

        // empty memory, halt at the top, fetch and bound cases, wrapping add and sub
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, MEM_SIZE - 1, OP_HALT);
        push_req(CMD_READ, MEM_SIZE - 1, 8'h00);
        push_req(CMD_SETPC, MEM_SIZE - 1, 8'hFF);
        push_req(CMD_EXEC, MEM_SIZE - 1, 8'hFF);
        push_req(CMD_WRITE, MEM_SIZE - 4, OP_ADD);
        push_req(CMD_SETPC, MEM_SIZE - 4, 0);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, 0, OP_ADD);
        push_req(CMD_WRITE, 1, 8'hFF);
        push_req(CMD_WRITE, 2, 8'h04);
        push_req(CMD_SETPC, 0, 0);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, 2, 8'h03);
        push_req(CMD_WRITE, 3, 8'hFF);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, 4, OP_BRANCH);
        push_req(CMD_WRITE, 5, 8'h80);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, 5, 8'hFC);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, 0, OP_SUB);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_WRITE, 4, OP_JUMP);
        push_req(CMD_WRITE, 5, 8'hFF);
        push_req(CMD_EXEC, 0, 0);
        push_req(CMD_READ, MEM_SIZE - 1, 0);

        goal = pending_reqs.size() + RANDOM_ITEMS;
        while (pending_reqs.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 60)
                queue_program();
            else if (pick < 80) begin
                at = $urandom_range(MEM_SIZE - 1);
                push_req(CMD_WRITE, at, $urandom_range(255));
                push_req(CMD_READ, $urandom_range(1) ? at : $urandom_range(MEM_SIZE - 1),
                         $urandom_range(255));
            end else
                push_req(CMD_W'($urandom), $urandom_range(MEM_SIZE - 1), $urandom_range(255));
        end
        total_items = pending_reqs.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
